@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the checker files
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, switched off while reset is low
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// concurrent check that also holds during reset
`define ASSERT_CLK(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/iopf_pkg.sv @@
// shared constants and types for the interleaved one-pole filter
// no dependencies; compile first after the macro header
package iopf_pkg;

	localparam int MAX_CHANNELS_DEF   = 8;
	localparam int SAMPLE_WIDTH_DEF   = 24;
	localparam int COEF_FRAC_BITS_DEF = 16;

	// width of the channel count register field, count after reset
	localparam int CHAN_FIELD_W     = 4;
	localparam int CHAN_COUNT_RESET = 2;

	localparam int CFG_INDEX_W = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_COEF  = 2'd0,
		REG_MODE  = 2'd1,
		REG_COUNT = 2'd2
	} cfg_reg_t;

	// per-cycle control for the channel state store
	typedef struct packed {
		logic adv;
		logic clr;
	} state_ctl_t;

endpackage

@@ hw/rtl/iopf_in_if.sv @@
// input sample channel: valid/ready plus one signed sample
// depends on iopf_pkg for the default sample width
interface iopf_in_if #(
	parameter int SAMPLE_WIDTH = iopf_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

@@ hw/rtl/iopf_out_if.sv @@
// result sample channel: valid/ready plus one signed sample
// depends on iopf_pkg for the default sample width
interface iopf_out_if #(
	parameter int SAMPLE_WIDTH = iopf_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

@@ hw/rtl/iopf_cfg.sv @@
// configuration registers: coefficient, mode and channel count
// depends on iopf_pkg; the count write also raises the state clear
module iopf_cfg #(
	parameter int MAX_CHANNELS   = iopf_pkg::MAX_CHANNELS_DEF,
	parameter int COEF_FRAC_BITS = iopf_pkg::COEF_FRAC_BITS_DEF,
	parameter int CNT_W          = $clog2(MAX_CHANNELS + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [iopf_pkg::CFG_INDEX_W-1:0]  wr_index,
	input  logic [COEF_FRAC_BITS:0]           wr_data,
	output logic [COEF_FRAC_BITS:0]           coef,
	output logic                              highpass,
	output logic [CNT_W-1:0]                  count,
	output logic                              clr
);
	import iopf_pkg::*;

	localparam logic [COEF_FRAC_BITS:0] COEF_ONE = {1'b1, {COEF_FRAC_BITS{1'b0}}};
	localparam int RST_COUNT =
		(CHAN_COUNT_RESET > MAX_CHANNELS) ? MAX_CHANNELS : CHAN_COUNT_RESET;

	logic [COEF_FRAC_BITS:0] coef_q;
	logic                    highpass_q;
	logic [CNT_W-1:0]        count_q;
	logic [COEF_FRAC_BITS:0] coef_d;
	logic [CNT_W-1:0]        count_d;
	logic [CHAN_FIELD_W-1:0] count_raw;
	int                      count_int;

	assign count_raw = wr_data[CHAN_FIELD_W-1:0];

	always_comb begin
		coef_d = (wr_data > COEF_ONE) ? COEF_ONE : wr_data;
		// zero means one channel, anything past the store saturates
		if (count_raw == '0) begin
			count_int = 1;
		end else if (int'(count_raw) > MAX_CHANNELS) begin
			count_int = MAX_CHANNELS;
		end else begin
			count_int = int'(count_raw);
		end
		count_d = CNT_W'(count_int);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q     <= COEF_ONE;
			highpass_q <= 1'b0;
			count_q    <= CNT_W'(RST_COUNT);
		end else if (wr_en) begin
			case (wr_index)
				REG_COEF: begin
					coef_q <= coef_d;
				end
				REG_MODE: begin
					highpass_q <= wr_data[0];
				end
				REG_COUNT: begin
					count_q <= count_d;
				end
				default: begin
				end
			endcase
		end
	end

	assign clr      = wr_en && (wr_index == REG_COUNT);
	assign coef     = coef_q;
	assign highpass = highpass_q;
	assign count    = count_q;

endmodule

@@ hw/rtl/iopf_state.sv @@
// per-channel history (previous input and output) and channel position
// depends on iopf_pkg for the control struct
module iopf_state #(
	parameter int MAX_CHANNELS = iopf_pkg::MAX_CHANNELS_DEF,
	parameter int SAMPLE_WIDTH = iopf_pkg::SAMPLE_WIDTH_DEF,
	parameter int CNT_W        = $clog2(MAX_CHANNELS + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  iopf_pkg::state_ctl_t           ctl,
	input  logic [CNT_W-1:0]               count,
	input  logic signed [SAMPLE_WIDTH-1:0] x_new,
	input  logic signed [SAMPLE_WIDTH-1:0] y_new,
	output logic signed [SAMPLE_WIDTH-1:0] x1,
	output logic signed [SAMPLE_WIDTH-1:0] y1
);
	import iopf_pkg::*;

	localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	logic signed [SAMPLE_WIDTH-1:0] prev_in_q  [MAX_CHANNELS];
	logic signed [SAMPLE_WIDTH-1:0] prev_out_q [MAX_CHANNELS];
	logic [POS_W-1:0]               pos_q;
	logic [POS_W-1:0]               ch;
	logic [POS_W-1:0]               ch_next;
	int                             ch_inc;

	always_comb begin
		ch      = (int'(pos_q) >= int'(count)) ? '0 : pos_q;
		ch_inc  = int'(ch) + 1;
		ch_next = (ch_inc >= int'(count)) ? '0 : POS_W'(ch_inc);
	end

	assign x1 = prev_in_q[ch];
	assign y1 = prev_out_q[ch];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				prev_in_q[i]  <= '0;
				prev_out_q[i] <= '0;
			end
			pos_q <= '0;
		end else if (ctl.clr) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				prev_in_q[i]  <= '0;
				prev_out_q[i] <= '0;
			end
			pos_q <= '0;
		end else if (ctl.adv) begin
			prev_in_q[ch]  <= x_new;
			prev_out_q[ch] <= y_new;
			pos_q          <= ch_next;
		end
	end

endmodule

@@ hw/rtl/iopf_calc.sv @@
// one-pole arithmetic: one shared multiplier, floor shift, saturation
// depends on iopf_pkg for default widths; purely combinational
module iopf_calc #(
	parameter int SAMPLE_WIDTH   = iopf_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = iopf_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic signed [SAMPLE_WIDTH-1:0] x,
	input  logic signed [SAMPLE_WIDTH-1:0] x1,
	input  logic signed [SAMPLE_WIDTH-1:0] y1,
	input  logic [COEF_FRAC_BITS:0]        coef,
	input  logic                           highpass,
	output logic signed [SAMPLE_WIDTH-1:0] y
);
	import iopf_pkg::*;

	localparam int SW     = SAMPLE_WIDTH;
	localparam int F      = COEF_FRAC_BITS;
	localparam int PROD_W = F + SW + 4;
	localparam int SUM_W  = SW + 5;
	localparam logic [F:0] COEF_ONE = {1'b1, {F{1'b0}}};

	logic signed [SW+1:0]     x_e;
	logic signed [SW+1:0]     x1_e;
	logic signed [SW+1:0]     y1_e;
	logic signed [SW+1:0]     diff;
	logic signed [SW+1:0]     hsum;
	logic [F:0]               mul_a;
	logic signed [SW+1:0]     mul_b;
	logic signed [F+1:0]      mul_a_s;
	logic signed [PROD_W-1:0] prod;
	logic signed [SW+3:0]     shifted;
	logic signed [SW+3:0]     base;
	logic signed [SUM_W-1:0]  sum;
	logic                     in_range;

	assign x_e  = {{2{x[SW-1]}}, x};
	assign x1_e = {{2{x1[SW-1]}}, x1};
	assign y1_e = {{2{y1[SW-1]}}, y1};

	// lowpass: b*(x - y1) added to y1; highpass: (1-b)*(y1 + x - x1)
	assign diff  = x_e - y1_e;
	assign hsum  = y1_e + x_e - x1_e;
	assign mul_a = highpass ? (COEF_ONE - coef) : coef;
	assign mul_b = highpass ? hsum : diff;

	assign mul_a_s = {1'b0, mul_a};
	assign prod    = mul_a_s * mul_b;

	// dropping the fraction bits of a two's complement value floors it
	assign shifted = prod[PROD_W-1:F];
	assign base    = highpass ? '0 : {{2{y1[SW-1]}}, y1_e};
	assign sum     = {base[SW+3], base} + {shifted[SW+3], shifted};

	assign in_range = (sum[SUM_W-1:SW-1] == '0) || (sum[SUM_W-1:SW-1] == '1);

	always_comb begin
		if (in_range) begin
			y = sum[SW-1:0];
		end else if (sum[SUM_W-1]) begin
			y = {1'b1, {(SW-1){1'b0}}};
		end else begin
			y = {1'b0, {(SW-1){1'b1}}};
		end
	end

endmodule

@@ hw/rtl/interleaved_one_pole_filter.sv @@
// Interleaved one-pole lowpass/highpass filter, top level.
//
// Samples of an interleaved stream arrive one per beat on in_ch; the block
// assigns them to channels 0, 1, .., count-1 in turn and wraps. Each result
// beat on out_ch carries the filtered sample of the matching input beat, in
// order. Registers are written through wr_en / wr_index / wr_data while the
// stream is idle: 0 coefficient (Q1.16, clipped to 1.0), 1 highpass select,
// 2 channel count (clipped to 1..MAX_CHANNELS; any write clears history).
//
// Each sample taken on in_ch is held in the input register, then passes
// through the history read, one multiplier and saturation into the output
// register, with the history written back on the same edge. Throughput:
// one sample per cycle while out_ch does not stall. When out_ch stalls, the
// input register holds one more beat and then in_ch.ready drops until the
// output register is taken.
// Reset: history and position clear at once, coefficient 1.0, lowpass,
// two channels; no clearing pass is needed.
module interleaved_one_pole_filter #(
	parameter int MAX_CHANNELS   = iopf_pkg::MAX_CHANNELS_DEF,
	parameter int SAMPLE_WIDTH   = iopf_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = iopf_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	iopf_in_if.sink                          in_ch,
	iopf_out_if.source                       out_ch,
	input  logic                             wr_en,
	input  logic [iopf_pkg::CFG_INDEX_W-1:0] wr_index,
	input  logic [COEF_FRAC_BITS:0]          wr_data
);
	import iopf_pkg::*;

	localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

	logic                           valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] x_s1;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] y_q;
	logic                           adv;
	logic                           take;

	logic [COEF_FRAC_BITS:0]        coef;
	logic                           highpass;
	logic [CNT_W-1:0]               count;
	logic                           clr;
	state_ctl_t                     st_ctl;
	logic signed [SAMPLE_WIDTH-1:0] x1;
	logic signed [SAMPLE_WIDTH-1:0] y1;
	logic signed [SAMPLE_WIDTH-1:0] y;

	// the input register moves on whenever the output register is free
	assign adv          = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || adv;
	assign take         = in_ch.valid && in_ch.ready;

	assign st_ctl.adv = adv;
	assign st_ctl.clr = clr;

	iopf_cfg #(
		.MAX_CHANNELS   (MAX_CHANNELS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.CNT_W          (CNT_W)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.coef     (coef),
		.highpass (highpass),
		.count    (count),
		.clr      (clr)
	);

	iopf_state #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.CNT_W        (CNT_W)
	) u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (st_ctl),
		.count  (count),
		.x_new  (x_s1),
		.y_new  (y),
		.x1     (x1),
		.y1     (y1)
	);

	iopf_calc #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_calc (
		.x        (x_s1),
		.x1       (x1),
		.y1       (y1),
		.coef     (coef),
		.highpass (highpass),
		.y        (y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_s1 <= in_ch.sample_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_q <= y;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = y_q;

endmodule

@@ hw/rtl/iopf_checker.sv @@
// port-level checks for the interleaved one-pole filter, bound to the top
// depends on iopf_pkg and assert_macros.svh
`include "assert_macros.svh"

module iopf_port_checker #(
	parameter int SAMPLE_WIDTH = iopf_pkg::SAMPLE_WIDTH_DEF
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [SAMPLE_WIDTH-1:0] out_data
);
	logic in_beat;
	logic out_stall;

	assign in_beat   = in_valid && in_ready;
	assign out_stall = out_valid && !out_ready;

	// a result held back must stay offered, unchanged
	`ASSERT_CLK_RST(a_out_hold, clk, arst_n, out_stall |=> out_valid, "result dropped while stalled")
	`ASSERT_CLK_RST(a_out_stable, clk, arst_n, out_stall |=> $stable(out_data), "result changed while stalled")
	// an empty output register means the block can always take a beat
	`ASSERT_CLK_RST(a_ready_when_empty, clk, arst_n, !out_valid |-> in_ready, "input blocked with empty output")
	// a fresh result comes from a beat taken into the input register before it
	`ASSERT_CLK_RST(a_out_from_beat, clk, arst_n, $rose(out_valid) |-> $past(in_beat, 2), "result without input beat")
	// an edge under reset leaves nothing offered at the next one
	`ASSERT_CLK(a_reset_quiet, clk, !arst_n |=> !out_valid, "result offered during reset")

endmodule

bind interleaved_one_pole_filter iopf_port_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_iopf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.sample_out)
);

@@ bench/iopf_checker.sv @@
// result checker for the interleaved one-pole filter: watches both sample channels
// and the register port, predicts each result and compares it with the result beat
// depends on iopf_pkg
`timescale 1ns / 1ps
module iopf_checker #(
	parameter int MAX_CHANNELS   = iopf_pkg::MAX_CHANNELS_DEF,
	parameter int SAMPLE_WIDTH   = iopf_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = iopf_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [SAMPLE_WIDTH-1:0]            in_sample,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [SAMPLE_WIDTH-1:0]            out_sample,
	input  logic                               wr_en,
	input  logic [iopf_pkg::CFG_INDEX_W-1:0]   wr_index,
	input  logic [COEF_FRAC_BITS:0]            wr_data,
	output int                                 outstanding,
	output int                                 fail_count
);
	import iopf_pkg::*;

	localparam longint COEF_ONE   = longint'(1) << COEF_FRAC_BITS;
	localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
	localparam longint SAMPLE_MIN = -(longint'(1) << (SAMPLE_WIDTH - 1));

	longint                  coef;
	logic                    highpass;
	int                      chan_count;
	int                      position;
	longint                  last_out [MAX_CHANNELS];
	longint                  last_in [MAX_CHANNELS];
	logic [SAMPLE_WIDTH-1:0] filtered_q [$];

	function automatic void clear_history();
		for (int i = 0; i < MAX_CHANNELS; i++) begin
			last_out[i] = 0;
			last_in[i]  = 0;
		end
		position = 0;
	endfunction

	function automatic void apply_write(logic [CFG_INDEX_W-1:0] idx,
			logic [COEF_FRAC_BITS:0] data);
		int n;
		case (idx)
			REG_COEF: begin
				coef = (longint'(data) > COEF_ONE) ? COEF_ONE : longint'(data);
			end
			REG_MODE: begin
				highpass = data[0];
			end
			REG_COUNT: begin
				n = int'(data[CHAN_FIELD_W-1:0]);
				if (n == 0)
					n = 1;
				if (n > MAX_CHANNELS)
					n = MAX_CHANNELS;
				chan_count = n;
				clear_history();
			end
			default: ;
		endcase
	endfunction

	// one filter step on the current channel, history updated, position advanced
	function automatic logic [SAMPLE_WIDTH-1:0] filter_sample(logic [SAMPLE_WIDTH-1:0] raw);
		int     ch;
		longint x;
		longint y1;
		longint x1;
		longint y;
		ch = position;
		if (ch >= chan_count)
			ch = 0;
		x  = longint'($signed(raw));
		y1 = last_out[ch];
		x1 = last_in[ch];
		if (!highpass)
			y = y1 + ((coef * (x - y1)) >>> COEF_FRAC_BITS);
		else
			y = ((COEF_ONE - coef) * (y1 + x - x1)) >>> COEF_FRAC_BITS;
		if (y > SAMPLE_MAX)
			y = SAMPLE_MAX;
		if (y < SAMPLE_MIN)
			y = SAMPLE_MIN;
		last_in[ch]  = x;
		last_out[ch] = y;
		position = (ch + 1 >= chan_count) ? 0 : ch + 1;
		return y[SAMPLE_WIDTH-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [SAMPLE_WIDTH-1:0] want;
		if (!arst_n) begin
			coef       = COEF_ONE;
			highpass   = 1'b0;
			chan_count = CHAN_COUNT_RESET;
			clear_history();
			filtered_q.delete();
			outstanding = 0;
			fail_count  = 0;
		end else begin
			if (wr_en)
				apply_write(wr_index, wr_data);
			if (in_valid && in_ready)
				filtered_q.push_back(filter_sample(in_sample));
			if (out_valid && out_ready) begin
				if (filtered_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result beat with none expected, got %0d",
							$realtime, $signed(out_sample));
				end else begin
					want = filtered_q.pop_front();
					if (out_sample !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: sample_out expected %0d, got %0d",
								$realtime, $signed(want), $signed(out_sample));
					end
				end
			end
			outstanding = filtered_q.size();
		end
	end

endmodule

@@ bench/tb_top.sv @@
// testbench top for the interleaved one-pole filter: clock, reset, stimulus and verdict
// depends on iopf_pkg, iopf_in_if, iopf_out_if, the filter rtl and iopf_checker
`timescale 1ns / 1ps
module tb_top;
	import iopf_pkg::*;

	localparam int SW     = SAMPLE_WIDTH_DEF;
	localparam int CW     = COEF_FRAC_BITS_DEF + 1;
	localparam int COEF_1 = 1 << COEF_FRAC_BITS_DEF;

	localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE = 2'd3;

	localparam logic [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

	localparam int IDLE_PCT        = 29;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int SETTLE_CYCLES   = 4;
	localparam int RANDOM_ITEMS    = 1650;
	localparam int WATCHDOG_LIMIT  = 5000;

	logic                   clk;
	logic                   arst_n;
	logic                   wr_en;
	logic [CFG_INDEX_W-1:0] wr_index;
	logic [CW-1:0]          wr_data;
	logic                   steady;
	logic                   hold_off_req;
	int                     outstanding;
	int                     fail_count;
	int                     quiet_cycles;

	iopf_in_if #(.SAMPLE_WIDTH(SW)) in_ch ();
	iopf_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

	interleaved_one_pole_filter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	iopf_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.in_sample   (in_ch.sample_in),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.out_sample  (out_ch.sample_out),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// result side: random stalls, one long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else begin
				out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("interleaved_one_pole_filter: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// called at a falling edge, returns at the falling edge after the beat is taken
	task automatic send_sample(input logic [SW-1:0] s);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.sample_in <= s;
		do
			@(posedge clk);
		while (!in_ch.ready);
		@(negedge clk);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain();
		in_ch.valid <= 1'b0;
		wait (outstanding == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CW-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [SW-1:0] random_sample();
		case ($urandom_range(0, 9))
			0:       return SAMPLE_MAX;
			1:       return SAMPLE_MIN;
			2, 3:    return SW'($urandom_range(0, 2047) - 1024);
			default: return SW'($urandom);
		endcase
	endfunction

	function automatic logic [CW-1:0] random_coef();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return CW'(COEF_1);
			2:       return CW'($urandom_range(COEF_1 + 1, 2 * COEF_1 - 1));
			3:       return CW'($urandom_range(1, 512));
			default: return CW'($urandom_range(0, COEF_1));
		endcase
	endfunction

	initial begin
		logic [SW-1:0] opening [6];
		logic [CW-1:0] d;
		int            phase;
		int            n;
		int            sent;

		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.sample_in = '0;
		wr_en           = 1'b0;
		wr_index        = '0;
		wr_data         = '0;
		steady          = 1'b0;
		hold_off_req    = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: two channels, lowpass at full strength
		opening = '{SAMPLE_MAX, SAMPLE_MIN, '0, '1, SW'(1), SAMPLE_MAX};
		foreach (opening[i])
			send_sample(opening[i]);

		// highpass sum running over the top: history holds the most negative input
		drain();
		write_reg(REG_COUNT, CW'(1));
		write_reg(REG_COEF, '0);
		send_sample(SAMPLE_MIN);
		drain();
		write_reg(REG_MODE, CW'(1));
		send_sample(SAMPLE_MAX);

		// and under the bottom, after a fresh clear
		drain();
		write_reg(REG_MODE, '0);
		write_reg(REG_COUNT, CW'(1));
		send_sample(SAMPLE_MAX);
		drain();
		write_reg(REG_MODE, CW'(1));
		send_sample(SAMPLE_MIN);

		// coefficient above one, channel count of zero
		drain();
		write_reg(REG_COEF, '1);
		write_reg(REG_MODE, '0);
		write_reg(REG_COUNT, '0);
		send_sample(SW'(12345));
		send_sample(SAMPLE_MIN);
		drain();
		write_reg(CFG_INDEX_SPARE, '1);

		// channel count beyond the maximum, highpass with coefficient 1.0, full wrap
		drain();
		write_reg(REG_COUNT, '1);
		write_reg(REG_MODE, CW'(1));
		for (int i = 0; i < 9; i++)
			send_sample(random_sample());

		phase = 0;
		sent  = 0;
		while (sent < RANDOM_ITEMS) begin
			drain();
			phase++;
			if ($urandom_range(0, 9) < 7)
				write_reg(REG_COEF, random_coef());
			if ($urandom_range(0, 9) < 6) begin
				d = CW'($urandom);
				d[0] = 1'($urandom_range(0, 1));
				write_reg(REG_MODE, d);
			end
			if ($urandom_range(0, 9) < 4) begin
				d = CW'($urandom);
				d[CHAN_FIELD_W-1:0] = ($urandom_range(0, 4) == 0) ?
					CHAN_FIELD_W'($urandom) : CHAN_FIELD_W'($urandom_range(1, 8));
				write_reg(REG_COUNT, d);
			end
			if ($urandom_range(0, 9) == 0)
				write_reg(CFG_INDEX_SPARE, CW'($urandom));

			steady = (phase == 4);
			if (phase == 6)
				hold_off_req = 1'b1;
			n = $urandom_range(20, 120);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 49) == 0) begin
					// sender pause until the pipe is empty
					in_ch.valid <= 1'b0;
					wait (outstanding == 0);
					@(negedge clk);
				end
				send_sample(random_sample());
			end
			sent += n;
		end
		steady = 1'b0;

		drain();
		if (fail_count == 0)
			$display("interleaved_one_pole_filter: match");
		else
			$display("interleaved_one_pole_filter: mismatch");
		$finish;
	end

endmodule
